@@ rtl/hkb_pkg.sv @@
// Shared types, constants and helper functions of the key-to-bucket hash block.
// Holds the register and selector codes, the hash constants and the tabulation words.
// No dependencies.
package hkb_pkg;

  // Sizes
  localparam int TABLE_COUNT   = 8;
  localparam int TABLE_ENTRIES = 256;
  localparam int MAX_ROUNDS    = 8;
  localparam int KEY_W         = 64;
  localparam int BUCKET_W      = 30;
  localparam int N_W           = 28;
  localparam int CFG_AW        = 3;
  localparam int CFG_DW        = 28;
  localparam int IN_DW         = 64;
  localparam int OUT_DW        = 32;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_HASH_SELECT     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_RANGE_N         = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEY_BYTES       = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY_SIGNED      = 3'd3;
  localparam logic [CFG_AW-1:0] REG_UPDATE_ROUNDS   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_FINALIZE_ROUNDS = 3'd5;

  // Hash selector codes
  localparam logic [2:0] HS_MODULO     = 3'd0;
  localparam logic [2:0] HS_TABULATION = 3'd1;
  localparam logic [2:0] HS_MULT_SHIFT = 3'd2;
  localparam logic [2:0] HS_MULT_ADD   = 3'd3;
  localparam logic [2:0] HS_MULT_PRIME = 3'd4;
  localparam logic [2:0] HS_MURMUR     = 3'd5;
  localparam logic [2:0] HS_NOISE      = 3'd6;
  localparam logic [2:0] HS_SIPHASH    = 3'd7;

  // Hash constants
  localparam logic [63:0] SIP_V0     = 64'h736f6d6570736575;
  localparam logic [63:0] SIP_V1     = 64'h646f72616e646f6d;
  localparam logic [63:0] SIP_V2     = 64'h6c7967656e657261;
  localparam logic [63:0] SIP_V3     = 64'h7465646279746573;
  localparam logic [63:0] MUR_MUL1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MUR_MUL2   = 64'hc4ceb9fe1a85ec53;
  localparam logic [63:0] NOISE_MUL1 = 64'h300a8352005996ae;
  localparam logic [63:0] NOISE_ADD  = 64'h512eb6f10ed4909d;
  localparam logic [63:0] NOISE_MUL2 = 64'hae2008421fd52b1f;
  localparam logic [31:0] PRIME_MUL  = 32'h618FE02F;
  localparam logic [63:0] PRIME_ADD  = 64'h7FFFFFFE ^ 64'h618FE02F;
  localparam logic [33:0] PRIME_MOD  = 34'h07FFFFFFF;
  localparam logic [63:0] MAS_MUL    = 64'hE18FA2826236E02F;
  localparam logic [63:0] MAS_ADD    = 64'h1E705D7D9DC91FD1;
  localparam logic [31:0] MS_MUL     = 32'h4D7C6D4D;
  localparam logic [63:0] TAB_SEED   = 64'hfa7343;

  // Pipeline layout: stage where each hash joins the result line
  localparam int MOD_BITS    = 2;
  localparam int MOD_STAGES  = KEY_W / MOD_BITS;
  localparam int SIP_STAGES  = 3 * MAX_ROUNDS;
  localparam int ST_TAB      = 3;
  localparam int ST_MS       = 3;
  localparam int ST_MAS      = 3;
  localparam int ST_PRIME    = 5;
  localparam int ST_MURMUR   = 6;
  localparam int ST_NOISE    = 7;
  localparam int ST_SIP      = SIP_STAGES + 2;
  localparam int ST_MOD      = MOD_STAGES + 1;
  localparam int LAST        = (ST_MOD > ST_SIP) ? ST_MOD : ST_SIP;

  typedef logic [3:0][63:0] sip_v_t;

  // Partial products of a 64 x 64 multiply, low 64 bits kept
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  typedef logic [TABLE_ENTRIES-1:0][31:0] tab_row_t;
  typedef tab_row_t [TABLE_COUNT-1:0] tab_t;

  function automatic pp_t mul_pp(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = 64'(a[31:0]) * 64'(b[31:0]);
    p.lh = a[31:0] * b[63:32];
    p.hl = a[63:32] * b[31:0];
    return p;
  endfunction

  function automatic logic [63:0] mul_sum(input pp_t p);
    logic [31:0] hi;
    hi = p.ll[63:32] + p.lh + p.hl;
    return {hi, p.ll[31:0]};
  endfunction

  // Range reduction product: operand times bucket count
  function automatic logic [59:0] red_mul(input logic [31:0] a, input logic [N_W-1:0] n);
    return 60'(a) * 60'(n);
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] x, input int s);
    return (x << s) | (x >> (64 - s));
  endfunction

  // One compression round
  function automatic sip_v_t sip_round(input sip_v_t v);
    logic [63:0] v0, v1, v2, v3;
    v0 = v[0]; v1 = v[1]; v2 = v[2]; v3 = v[3];
    v0 = v0 + v1; v2 = v2 + v3;
    v1 = rotl(v1, 13); v3 = rotl(v3, 16);
    v1 = v1 ^ v0; v3 = v3 ^ v2;
    v0 = rotl(v0, 32);
    v2 = v2 + v1; v0 = v0 + v3;
    v1 = rotl(v1, 17); v3 = rotl(v3, 21);
    v1 = v1 ^ v2; v3 = v3 ^ v0;
    v2 = rotl(v2, 32);
    return {v3, v2, v1, v0};
  endfunction

  // Restoring remainder, MOD_BITS dividend bits per call
  function automatic logic [N_W-1:0] mod_step(input logic [N_W-1:0] rem,
                                              input logic [MOD_BITS-1:0] bits,
                                              input logic [N_W-1:0] n);
    logic [N_W:0]   t;
    logic [N_W-1:0] r;
    r = rem;
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, n}) t = t - {1'b0, n};
      r = t[N_W-1:0];
    end
    return r;
  endfunction

  // Elaboration-time helpers for the tabulation words
  function automatic logic [63:0] noise_mix(input logic [63:0] k, input logic [63:0] n);
    logic [63:0] m;
    m = k * NOISE_MUL1;
    m = m + n;
    m = m ^ (m << 13);
    m = m + NOISE_ADD;
    m = m ^ (m >> 7);
    m = m * NOISE_MUL2;
    m = m ^ (m << 17);
    return m;
  endfunction

  function automatic logic [63:0] ref_reduce(input logic [63:0] v, input logic [63:0] n);
    int          b;
    logic [63:0] a;
    b = 0;
    for (int i = 0; i < 64; i++) if (n[i]) b = i + 1;
    b = b + 4;
    a = {32'b0, v[31:0]};
    if (b < 32) a = a & (64'hFFFFFFFF >> (32 - b));
    return (a * n) >> b;
  endfunction

  function automatic tab_t gen_tab();
    tab_t        t;
    logic [63:0] seed;
    for (int i = 0; i < TABLE_COUNT; i++) begin
      seed = TAB_SEED + 64'(i);
      for (int e = 0; e < TABLE_ENTRIES; e++)
        t[i][e] = 32'(ref_reduce(noise_mix(64'(e), seed), seed));
    end
    return t;
  endfunction

  localparam tab_t TAB_WORDS = gen_tab();

endpackage

@@ rtl/hash_key_to_bucket.sv @@
// Key-to-bucket hash: eight selectable hashes, all computed in one pipeline.
// Throughput: one item per cycle while the output is not held; depth is set by the
// radix-4 remainder stages and the SipHash round stages (one round per stage,
// 3 x MAX_ROUNDS of them).
// Reset (rst_n low, synchronous) empties the pipeline and restores registers;
// tabulation words are constants, so no clearing pass is needed.
module hash_key_to_bucket (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hkb_pkg::IN_DW-1:0]     in_tdata,   // [63:0] key
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hkb_pkg::OUT_DW-1:0]    out_tdata,  // [29:0] bucket, [31:30] zero
  input  logic                          cfg_we,
  input  logic [hkb_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [hkb_pkg::CFG_DW-1:0]    cfg_wdata
);
  import hkb_pkg::*;

  // Configuration registers
  logic [2:0]     hash_select_r;
  logic [N_W-1:0] range_n_r;
  logic [3:0]     key_bytes_r;
  logic           key_signed_r;
  logic [3:0]     update_rounds_r;
  logic [3:0]     finalize_rounds_r;
  logic [5:0]     rb_r, rb_nxt;
  logic [31:0]    rmask_r, rmask_nxt;

  logic           adv;
  logic           vld_r [0:LAST];
  logic [BUCKET_W-1:0] res_r [1:LAST];
  logic [BUCKET_W-1:0] res_nxt [1:LAST];

  logic [3:0]     kb;
  logic [2:0]     kb_m1;
  logic           sgn;
  logic [63:0]    kp, k0_r;
  logic [63:0]    n64;

  // Lane registers
  logic [31:0] tab_x, tab_t_r;
  logic [59:0] tab_p_r;
  logic [31:0] ms_lo_r;
  logic [59:0] ms_p_r;
  logic [31:0] mas_lo_r;
  logic [59:0] mas_p_r;
  pp_t         pr_pp_r;
  logic [63:0] pr_y_r;
  logic [33:0] pr_z_nxt, pr_z_r;
  logic [61:0] pr_p_r;
  pp_t         mu_pp1_r, mu_pp2_r;
  logic [63:0] mu_s1, mu_y1_r, mu_s2;
  logic [31:0] mu_a_r;
  logic [59:0] mu_p_r;
  pp_t         no_pp1_r, no_pp2_r;
  logic [63:0] no_m1, no_m1_r, no_m2, no_m2_r, no_m3;
  logic [31:0] no_a_r;
  logic [59:0] no_p_r;
  sip_v_t      sip_in  [1:SIP_STAGES];
  sip_v_t      sip_nxt [1:SIP_STAGES];
  sip_v_t      sip_v_r [1:SIP_STAGES];
  logic [63:0] sip_k_r [1:MAX_ROUNDS];
  logic [63:0] sip_f;
  logic [59:0] sip_p_r;
  logic [N_W-1:0]   mod_rem_nxt [1:MOD_STAGES];
  logic [N_W-1:0]   mod_rem_r   [1:MOD_STAGES];
  logic [KEY_W-1:0] mod_dvd_r   [1:MOD_STAGES-1];

  // Global advance: the whole pipe moves unless the output item is held
  assign adv        = !vld_r[LAST] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = {{(OUT_DW - BUCKET_W){1'b0}}, res_r[LAST]};
  assign n64        = {{(64 - N_W){1'b0}}, range_n_r};

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_select_r     <= HS_SIPHASH;
      range_n_r         <= 28'd1024;
      key_bytes_r       <= 4'd8;
      key_signed_r      <= 1'b0;
      update_rounds_r   <= 4'd2;
      finalize_rounds_r <= 4'd2;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HASH_SELECT:     hash_select_r     <= cfg_wdata[2:0];
        REG_RANGE_N:         range_n_r         <= cfg_wdata[N_W-1:0];
        REG_KEY_BYTES:       key_bytes_r       <= cfg_wdata[3:0];
        REG_KEY_SIGNED:      key_signed_r      <= cfg_wdata[0];
        REG_UPDATE_ROUNDS:   update_rounds_r   <= cfg_wdata[3:0];
        REG_FINALIZE_ROUNDS: finalize_rounds_r <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Reduction width: bit length of N plus four, and its low-bit mask
  always_comb begin
    logic [4:0] bl;
    bl = 5'd0;
    for (int i = 0; i < N_W; i++) if (range_n_r[i]) bl = 5'(i + 1);
    rb_nxt    = 6'(bl) + 6'd4;
    rmask_nxt = (rb_nxt >= 6'd32) ? 32'hFFFFFFFF : ((32'd1 << rb_nxt) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rb_r    <= 6'd15;
      rmask_r <= 32'h00007FFF;
    end else begin
      rb_r    <= rb_nxt;
      rmask_r <= rmask_nxt;
    end
  end

  // Cut the key to its width and extend it
  always_comb begin
    kb    = (key_bytes_r == 4'd0 || key_bytes_r > 4'd8) ? 4'd8 : key_bytes_r;
    kb_m1 = 3'(kb - 4'd1);
    sgn   = key_signed_r & in_tdata[{kb_m1, 3'b111}];
    for (int i = 0; i < 8; i++)
      kp[8*i +: 8] = (4'(i) < kb) ? in_tdata[8*i +: 8] : {8{sgn}};
  end

  // Valid line
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s <= LAST; s++) vld_r[s] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int s = 1; s <= LAST; s++) vld_r[s] <= vld_r[s-1];
    end
  end

  // Lane logic between stages
  always_comb begin
    tab_x = '0;
    for (int i = 0; i < TABLE_COUNT; i++)
      if (4'(i) < kb) tab_x = tab_x ^ TAB_WORDS[i][k0_r[8*i +: 8]];

    pr_z_nxt = 34'(pr_y_r[30:0]) + 34'(pr_y_r[63:31]);
    if (pr_z_nxt >= PRIME_MOD) pr_z_nxt = pr_z_nxt - PRIME_MOD;

    mu_s1 = mul_sum(mu_pp1_r);
    mu_s2 = mul_sum(mu_pp2_r);
    mu_s1 = mu_s1 ^ (mu_s1 >> 33);
    mu_s2 = mu_s2 ^ (mu_s2 >> 33);

    no_m1 = mul_sum(no_pp1_r) + n64;
    no_m1 = no_m1 ^ (no_m1 << 13);
    no_m2 = no_m1_r + NOISE_ADD;
    no_m2 = no_m2 ^ (no_m2 >> 7);
    no_m3 = mul_sum(no_pp2_r);
    no_m3 = no_m3 ^ (no_m3 << 17);

    sip_f = sip_v_r[SIP_STAGES][0] ^ sip_v_r[SIP_STAGES][1] ^
            sip_v_r[SIP_STAGES][2] ^ sip_v_r[SIP_STAGES][3];
  end

  // SipHash round stages: key block, N block, then finalisation
  always_comb begin
    sip_in[1] = {SIP_V3 ^ k0_r, SIP_V2, SIP_V1, SIP_V0};
    for (int j = 2; j <= SIP_STAGES; j++) begin
      sip_in[j] = sip_v_r[j-1];
      if (j == MAX_ROUNDS + 1) begin
        sip_in[j][0] = sip_in[j][0] ^ sip_k_r[MAX_ROUNDS];
        sip_in[j][3] = sip_in[j][3] ^ n64;
      end
      if (j == 2 * MAX_ROUNDS + 1) begin
        sip_in[j][0] = sip_in[j][0] ^ n64;
        sip_in[j][2] = sip_in[j][2] ^ 64'hFF;
      end
    end
    for (int j = 1; j <= SIP_STAGES; j++) begin
      if (((j - 1) % MAX_ROUNDS) <
          int'((j <= 2 * MAX_ROUNDS) ? update_rounds_r : finalize_rounds_r))
        sip_nxt[j] = sip_round(sip_in[j]);
      else
        sip_nxt[j] = sip_in[j];
    end
  end

  // Remainder stages, two dividend bits each
  always_comb begin
    mod_rem_nxt[1] = mod_step('0, k0_r[KEY_W-1 -: MOD_BITS], range_n_r);
    for (int j = 2; j <= MOD_STAGES; j++)
      mod_rem_nxt[j] = mod_step(mod_rem_r[j-1], mod_dvd_r[j-1][KEY_W-1 -: MOD_BITS],
                                range_n_r);
  end

  // Payload registers of every lane
  always_ff @(posedge clk) begin
    if (adv) begin
      k0_r     <= kp;
      tab_t_r  <= tab_x;
      tab_p_r  <= red_mul(tab_t_r, range_n_r);
      ms_lo_r  <= (MS_MUL ^ 32'(range_n_r)) * k0_r[31:0];
      ms_p_r   <= red_mul(ms_lo_r & rmask_r, range_n_r);
      mas_lo_r <= k0_r[31:0] * MAS_MUL[31:0];
      mas_p_r  <= red_mul((mas_lo_r + MAS_ADD[31:0]) & rmask_r, range_n_r);
      pr_pp_r  <= mul_pp(k0_r, {32'b0, PRIME_MUL});
      pr_y_r   <= mul_sum(pr_pp_r) + PRIME_ADD;
      pr_z_r   <= pr_z_nxt;
      pr_p_r   <= 62'(pr_z_r) * 62'(range_n_r);
      mu_pp1_r <= mul_pp(k0_r ^ (k0_r >> 33), MUR_MUL1);
      mu_y1_r  <= mu_s1;
      mu_pp2_r <= mul_pp(mu_y1_r, MUR_MUL2);
      mu_a_r   <= mu_s2[31:0] & rmask_r;
      mu_p_r   <= red_mul(mu_a_r, range_n_r);
      no_pp1_r <= mul_pp(k0_r, NOISE_MUL1);
      no_m1_r  <= no_m1;
      no_m2_r  <= no_m2;
      no_pp2_r <= mul_pp(no_m2_r, NOISE_MUL2);
      no_a_r   <= no_m3[31:0] & rmask_r;
      no_p_r   <= red_mul(no_a_r, range_n_r);
      sip_p_r  <= red_mul(sip_f[31:0] & rmask_r, range_n_r);
      sip_k_r[1] <= k0_r;
      for (int j = 2; j <= MAX_ROUNDS; j++) sip_k_r[j] <= sip_k_r[j-1];
      for (int j = 1; j <= SIP_STAGES; j++) sip_v_r[j] <= sip_nxt[j];
      mod_dvd_r[1] <= k0_r << MOD_BITS;
      for (int j = 2; j < MOD_STAGES; j++) mod_dvd_r[j] <= mod_dvd_r[j-1] << MOD_BITS;
      for (int j = 1; j <= MOD_STAGES; j++) mod_rem_r[j] <= mod_rem_nxt[j];
    end
  end

  // Result line: the selected hash joins at its own stage, then rides to the output
  always_comb begin
    res_nxt[1] = '0;
    for (int s = 2; s <= LAST; s++) begin
      res_nxt[s] = res_r[s-1];
      if (s == ST_TAB && hash_select_r == HS_TABULATION)
        res_nxt[s] = BUCKET_W'(tab_p_r[59:32]);
      if (s == ST_MS && hash_select_r == HS_MULT_SHIFT)
        res_nxt[s] = BUCKET_W'(ms_p_r >> rb_r);
      if (s == ST_MAS && hash_select_r == HS_MULT_ADD)
        res_nxt[s] = BUCKET_W'(mas_p_r >> rb_r);
      if (s == ST_PRIME && hash_select_r == HS_MULT_PRIME)
        res_nxt[s] = pr_p_r[60:31];
      if (s == ST_MURMUR && hash_select_r == HS_MURMUR)
        res_nxt[s] = BUCKET_W'(mu_p_r >> rb_r);
      if (s == ST_NOISE && hash_select_r == HS_NOISE)
        res_nxt[s] = BUCKET_W'(no_p_r >> rb_r);
      if (s == ST_SIP && hash_select_r == HS_SIPHASH)
        res_nxt[s] = BUCKET_W'(sip_p_r >> rb_r);
      if (s == ST_MOD && hash_select_r == HS_MODULO)
        res_nxt[s] = (range_n_r == '0) ? '0 : BUCKET_W'(mod_rem_r[MOD_STAGES]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 1; s <= LAST; s++) res_r[s] <= res_nxt[s];
    end
  end

`ifndef ASSERT_OFF
  // An accepted item enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> vld_r[0])
    else $error("accepted item missing from first stage");

  // The output stage takes the valid of the stage before it on every advance
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_tvalid == $past(vld_r[LAST-1]))
    else $error("output valid does not follow the pipeline");

  // A stall only happens with an item waiting at the output, and it stays there
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> out_tvalid)
    else $error("stall without a held item");

  // Reduction width stays between four and thirty-two bits
  a_rb: assert property (@(posedge clk) disable iff (!rst_n)
    rb_r >= 6'd4 && rb_r <= 6'd32)
    else $error("reduction width out of range");
`endif

endmodule

@@ bench/hkb_bucket_checker.sv @@
// Bucket checker for hash_key_to_bucket: snoops the config port and both streams,
// predicts each bucket index and compares it with what the block returns.
// Depends on hkb_pkg for register and selector codes and port widths.
module hkb_bucket_checker
  import hkb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [63:0] key
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [OUT_DW-1:0] out_tdata,  // [29:0] bucket
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                fail_count,
  output int                buckets_due
);

  logic [2:0]           sel_q;
  logic [N_W-1:0]       buckets_q;
  logic [3:0]           width_q;
  logic                 signed_q;
  logic [3:0]           upd_rounds_q;
  logic [3:0]           fin_rounds_q;
  logic [31:0]          tab_words [TABLE_COUNT][TABLE_ENTRIES];
  logic [BUCKET_W-1:0]  bucket_q [$];

  // Bit length of n plus four, then scale the masked low word by n
  function automatic logic [63:0] scale_to_range(input logic [63:0] v, input logic [63:0] n);
    int          nb;
    logic [63:0] a;
    nb = 0;
    for (int i = 0; i < 64; i++) if (n[i]) nb = i + 1;
    nb = nb + 4;
    a = {32'b0, v[31:0]};
    if (nb < 32) a = a & (64'hFFFF_FFFF >> (32 - nb));
    return (a * n) >> nb;
  endfunction

  function automatic logic [63:0] scramble(input logic [63:0] k, input logic [63:0] n);
    logic [63:0] m;
    m = k * 64'h300a8352005996ae + n;
    m = m ^ (m << 13);
    m = m + 64'h512eb6f10ed4909d;
    m = m ^ (m >> 7);
    m = m * 64'hae2008421fd52b1f;
    m = m ^ (m << 17);
    return m;
  endfunction

  function automatic logic [63:0] rot_left(input logic [63:0] x, input int s);
    return (x << s) | (x >> (64 - s));
  endfunction

  // Run the given number of compression rounds on the four lanes
  function automatic void compress(ref logic [63:0] v [4], input int rounds);
    for (int i = 0; i < rounds; i++) begin
      v[0] += v[1]; v[2] += v[3];
      v[1] = rot_left(v[1], 13); v[3] = rot_left(v[3], 16);
      v[1] ^= v[0]; v[3] ^= v[2];
      v[0] = rot_left(v[0], 32);
      v[2] += v[1]; v[0] += v[3];
      v[1] = rot_left(v[1], 17); v[3] = rot_left(v[3], 21);
      v[1] ^= v[2]; v[3] ^= v[0];
      v[2] = rot_left(v[2], 32);
    end
  endfunction

  function automatic logic [BUCKET_W-1:0] predict_bucket(input logic [63:0] raw);
    int          nbytes, ur, fr;
    logic [63:0] k, n, r, y, z, msk;
    logic [31:0] t;
    logic [63:0] v [4];
    nbytes = (width_q == 0 || width_q > 8) ? 8 : width_q;
    ur = (upd_rounds_q > MAX_ROUNDS) ? MAX_ROUNDS : upd_rounds_q;
    fr = (fin_rounds_q > MAX_ROUNDS) ? MAX_ROUNDS : fin_rounds_q;
    n = 64'(buckets_q);
    k = raw;
    // Cut to key width, then extend
    if (nbytes < 8) begin
      msk = (64'd1 << (8 * nbytes)) - 1;
      k = k & msk;
      if (signed_q && k[8 * nbytes - 1]) k = k | ~msk;
    end
    case (sel_q)
      HS_MODULO:     r = (n != 0) ? k % n : 64'd0;
      HS_TABULATION: begin
        t = '0;
        for (int i = 0; i < nbytes && i < TABLE_COUNT; i++)
          t ^= tab_words[i][(k >> (8 * i)) & 64'hFF];
        r = (64'(t) * n) >> 32;
      end
      HS_MULT_SHIFT: r = scale_to_range((64'h4D7C6D4D ^ n) * k, n);
      HS_MULT_ADD:   r = scale_to_range(k * 64'hE18FA2826236E02F + 64'h1E705D7D9DC91FD1, n);
      HS_MULT_PRIME: begin
        y = 64'h618FE02F * k + (64'h7FFFFFFE ^ 64'h618FE02F);
        z = (y & 64'h7FFFFFFF) + (y >> 31);
        if (z >= 64'h7FFFFFFF) z = z - 64'h7FFFFFFF;
        r = (z * n) >> 31;
      end
      HS_MURMUR: begin
        y = k ^ (k >> 33);
        y = y * 64'hff51afd7ed558ccd;
        y = y ^ (y >> 33);
        y = y * 64'hc4ceb9fe1a85ec53;
        y = y ^ (y >> 33);
        r = scale_to_range(y, n);
      end
      HS_NOISE:      r = scale_to_range(scramble(k, n), n);
      default: begin
        v[0] = 64'h736f6d6570736575; v[1] = 64'h646f72616e646f6d;
        v[2] = 64'h6c7967656e657261; v[3] = 64'h7465646279746573;
        v[3] ^= k; compress(v, ur); v[0] ^= k;
        v[3] ^= n; compress(v, ur); v[0] ^= n;
        v[2] ^= 64'hFF;
        compress(v, fr);
        r = scale_to_range(v[0] ^ v[1] ^ v[2] ^ v[3], n);
      end
    endcase
    return r[BUCKET_W-1:0];
  endfunction

  // Fixed tabulation words, one table per key byte
  initial begin
    logic [63:0] seed;
    for (int i = 0; i < TABLE_COUNT; i++) begin
      seed = 64'hfa7343 + 64'(i);
      for (int e = 0; e < TABLE_ENTRIES; e++)
        tab_words[i][e] = 32'(scale_to_range(scramble(64'(e), seed), seed));
    end
  end

  // Track registers, queue predictions, compare returned buckets
  always @(posedge clk) begin
    if (!rst_n) begin
      sel_q <= HS_SIPHASH; buckets_q <= 28'd1024; width_q <= 4'd8;
      signed_q <= 1'b0; upd_rounds_q <= 4'd2; fin_rounds_q <= 4'd2;
      fail_count <= 0;
      bucket_q.delete();
      buckets_due <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_HASH_SELECT:     sel_q <= cfg_wdata[2:0];
          REG_RANGE_N:         buckets_q <= cfg_wdata[N_W-1:0];
          REG_KEY_BYTES:       width_q <= cfg_wdata[3:0];
          REG_KEY_SIGNED:      signed_q <= cfg_wdata[0];
          REG_UPDATE_ROUNDS:   upd_rounds_q <= cfg_wdata[3:0];
          REG_FINALIZE_ROUNDS: fin_rounds_q <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) bucket_q.push_back(predict_bucket(in_tdata));
      if (out_tvalid && out_tready) begin
        if (bucket_q.size() == 0) begin
          $error("bucket: result with none expected, actual %0d", out_tdata[BUCKET_W-1:0]);
          fail_count <= fail_count + 1;
        end else if (bucket_q[0] != out_tdata[BUCKET_W-1:0]) begin
          $error("bucket: expected %0d actual %0d", bucket_q[0], out_tdata[BUCKET_W-1:0]);
          fail_count <= fail_count + 1;
          void'(bucket_q.pop_front());
        end else begin
          void'(bucket_q.pop_front());
        end
      end
      // Publish the number of items still owed a bucket
      buckets_due <= bucket_q.size();
    end
  end

endmodule

@@ bench/tb_hash_key_to_bucket.sv @@
// Testbench top for hash_key_to_bucket: drives keys and register settings with
// random gaps and stalls, and reports the verdict from hkb_bucket_checker.
// Depends on hkb_pkg, hash_key_to_bucket and hkb_bucket_checker.
module tb_hash_key_to_bucket;
  import hkb_pkg::*;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;    // [63:0] key
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;        // [29:0] bucket
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;
  int                fail_count;
  int                buckets_due;
  bit                steady;          // no gaps or stalls in this phase
  int                left_over;

  always #10 clk = ~clk;

  hash_key_to_bucket uut (.*);
  hkb_bucket_checker chk (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver stalls
  always @(negedge clk) begin
    int hold;
    hold = pick_gap();
    out_tready = (hold == 0);
    repeat (hold) @(negedge clk);
    out_tready = 1'b1;
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1; cfg_addr = idx; cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Let all buckets return, then wait out the pipeline
  task automatic drain();
    while (buckets_due != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_regs(input logic [2:0] sel, input logic [27:0] n, input int kb,
                          input bit sgn, input int ur, input int fr);
    drain();
    write_reg(REG_HASH_SELECT, 28'(sel));
    write_reg(REG_RANGE_N, n);
    write_reg(REG_KEY_BYTES, 28'(kb));
    write_reg(REG_KEY_SIGNED, 28'(sgn));
    write_reg(REG_UPDATE_ROUNDS, 28'(ur));
    write_reg(REG_FINALIZE_ROUNDS, 28'(fr));
  endtask

  // Present one key, hold until taken
  task automatic send_key(input logic [63:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1; in_tdata = k;
    @(posedge clk iff in_tready);
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand_key();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return {1'b1, 63'(0)} | 64'($urandom_range(0, 255));
      3: return 64'($urandom_range(0, 255)) << (8 * $urandom_range(0, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [27:0] rand_range();
    case ($urandom_range(0, 5))
      0: return 28'd1;
      1: return 28'hFFFFFFF;
      2: return 28'($urandom_range(1, 64));
      default: return 28'($urandom_range(1, 28'hFFFFFFF));
    endcase
  endfunction

  initial begin
    logic [63:0] directed [3];
    directed[0] = 64'd0;
    directed[1] = '1;
    directed[2] = 64'h8000_0000_0000_0080;
    steady = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    // Directed: every hash at the extremes of keys and settings
    for (int s = 0; s < 8; s++) begin
      in_tvalid = 1'b0;
      set_regs(3'(s), (s % 2) ? 28'hFFFFFFF : 28'd1, (s < 4) ? 1 : 8, s[0],
               (s < 4) ? 1 : 8, (s < 4) ? 8 : 1);
      for (int i = 0; i < 3; i++) send_key(directed[i]);
    end
    in_tvalid = 1'b0;
    // Random phases
    for (int p = 0; p < 35; p++) begin
      in_tvalid = 1'b0;
      set_regs(3'($urandom_range(0, 7)), rand_range(), $urandom_range(1, 8),
               1'($urandom), $urandom_range(1, 8), $urandom_range(1, 8));
      steady = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < 50; i++) begin
        // Hold off until every bucket is back, once in a while
        if (i == 25 && p % 7 == 3) begin
          in_tvalid = 1'b0;
          while (buckets_due != 0) @(negedge clk);
        end
        send_key(rand_key());
      end
    end
    in_tvalid = 1'b0;
    steady = 1'b0;
    drain();
    left_over = buckets_due;
    if (left_over != 0)
      $error("bucket: %0d expected results never arrived", left_over);
    if (fail_count == 0 && left_over == 0) begin
      $display("tb_hash_key_to_bucket: clean");
    end else begin
      $display("tb_hash_key_to_bucket: errors");
    end
    $finish;
  end

  // Timeout
  initial begin
    #40000000;
    $display("tb_hash_key_to_bucket: errors");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hkb_pkg.sv
rtl/hash_key_to_bucket.sv
bench/hkb_bucket_checker.sv
bench/tb_hash_key_to_bucket.sv
